[src/detection_proximity_suppression_assert.svh]
// Assertion macros shared by the proximity suppression modules
`ifndef DETECTION_PROXIMITY_SUPPRESSION_ASSERT_SVH
`define DETECTION_PROXIMITY_SUPPRESSION_ASSERT_SVH
`ifndef SYNTH
// check a condition at every clock edge outside reset
`define DPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that a condition holds in the cycle after a trigger
`define DPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define DPS_ASSERT(lbl, prop, msg)
`define DPS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/dps_pkg.sv]
// Shared constants and types of the proximity suppression block
package dps_pkg;

	localparam int MAX_DETECTIONS_DEF = 32;
	localparam int COORD_BITS_DEF     = 12;
	localparam int CLASS_BITS         = 4;
	localparam int SCORE_BITS         = 16;
	localparam int DIST_BITS          = 26;
	localparam int KEEP_BITS          = 6;
	localparam int RESULT_LIMIT       = 32;
	localparam int ADDR_BITS          = 4;
	localparam int REG_IDX_BITS       = 2;

	localparam logic [DIST_BITS-1:0] NEAR_RESET = DIST_BITS'(50);
	localparam logic [DIST_BITS-1:0] FAR_RESET  = DIST_BITS'(20000);
	localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(3);

	localparam logic [REG_IDX_BITS-1:0] REG_NEAR = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_FAR  = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_KEEP = 2'd2;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_END = 1'b1;

	// one operation per cycle across the whole row of cells
	typedef struct packed {
		logic load;
		logic shift;
		logic kill;
		logic clear;
	} cell_ctrl_t;

endpackage

[src/dps_cell.sv]
// One cell of the sorted detection row: holds a detection and its survival bit
module dps_cell import dps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DET_W      = 2 * COORD_BITS + CLASS_BITS + SCORE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [DET_W-1:0]      new_det,
	input  logic [COORD_BITS-1:0] anchor_x,
	input  logic [COORD_BITS-1:0] anchor_y,
	input  logic [DIST_BITS-1:0]  near_dist_sq,
	input  logic [DIST_BITS-1:0]  far_dist_sq,
	input  logic [DET_W-1:0]      left_det,
	input  logic                  left_valid,
	input  logic                  left_alive,
	input  logic                  left_gt,
	input  logic [DET_W-1:0]      right_det,
	input  logic                  right_valid,
	input  logic                  right_alive,
	output logic [DET_W-1:0]      det,
	output logic                  valid,
	output logic                  alive,
	output logic                  gt
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > DIST_BITS) ? SUM_W : DIST_BITS;

	logic [DET_W-1:0]      det_q;
	logic                  valid_q;
	logic                  alive_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] new_y;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [SQ_W-1:0]       sq_x;
	logic [SQ_W-1:0]       sq_y;
	logic [CMP_W-1:0]      sq_sum;
	logic                  reject;
	logic                  take_left;
	logic                  take_new;

	assign x_q   = det_q[COORD_BITS-1:0];
	assign y_q   = det_q[2*COORD_BITS-1:COORD_BITS];
	assign new_y = new_det[2*COORD_BITS-1:COORD_BITS];

	// equal keys stay ahead of the new item, so arrival order holds on ties
	assign gt        = valid_q && (y_q > new_y);
	assign take_left = left_gt;
	assign take_new  = left_valid && !left_gt && (!valid_q || gt);

	assign dx     = (x_q > anchor_x) ? (x_q - anchor_x) : (anchor_x - x_q);
	assign dy     = (y_q > anchor_y) ? (y_q - anchor_y) : (anchor_y - y_q);
	assign sq_x   = SQ_W'(dx) * SQ_W'(dx);
	assign sq_y   = SQ_W'(dy) * SQ_W'(dy);
	assign sq_sum = CMP_W'(SUM_W'(sq_x) + SUM_W'(sq_y));
	assign reject = (sq_sum < CMP_W'(near_dist_sq)) || (sq_sum > CMP_W'(far_dist_sq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			alive_q <= 1'b0;
		end else begin
			priority if (ctrl.clear) begin
				valid_q <= 1'b0;
				alive_q <= 1'b0;
			end else if (ctrl.shift) begin
				valid_q <= right_valid;
				alive_q <= right_alive;
			end else if (ctrl.load) begin
				if (take_left) begin
					valid_q <= left_valid;
					alive_q <= left_alive;
				end else if (take_new) begin
					valid_q <= 1'b1;
					alive_q <= 1'b1;
				end
			end else if (ctrl.kill) begin
				if (valid_q && alive_q && reject) begin
					alive_q <= 1'b0;
				end
			end else begin
				// hold
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			det_q <= right_det;
		end else if (ctrl.load && take_left) begin
			det_q <= left_det;
		end else if (ctrl.load && take_new) begin
			det_q <= new_det;
		end
	end

	assign det   = det_q;
	assign valid = valid_q;
	assign alive = alive_q;

endmodule

[src/dps_chain.sv]
// Row of detection cells kept in ascending y order, head at cell zero
module dps_chain import dps_pkg::*; #(
	parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int DET_W          = 2 * COORD_BITS + CLASS_BITS + SCORE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [DET_W-1:0]      new_det,
	input  logic [COORD_BITS-1:0] anchor_x,
	input  logic [COORD_BITS-1:0] anchor_y,
	input  logic [DIST_BITS-1:0]  near_dist_sq,
	input  logic [DIST_BITS-1:0]  far_dist_sq,
	output logic [DET_W-1:0]      head_det,
	output logic                  head_valid,
	output logic                  head_alive,
	output logic                  any_alive
);
	`include "detection_proximity_suppression_assert.svh"

	logic [DET_W-1:0]          det_a [MAX_DETECTIONS];
	logic [MAX_DETECTIONS-1:0] valid_vec;
	logic [MAX_DETECTIONS-1:0] alive_vec;
	logic [MAX_DETECTIONS-1:0] gt_vec;

	for (genvar i = 0; i < MAX_DETECTIONS; i++) begin : g_cell
		logic [DET_W-1:0] l_det;
		logic             l_valid;
		logic             l_alive;
		logic             l_gt;
		logic [DET_W-1:0] r_det;
		logic             r_valid;
		logic             r_alive;

		if (i == 0) begin : g_first
			assign l_det   = '0;
			assign l_valid = 1'b1;
			assign l_alive = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_mid
			assign l_det   = det_a[i-1];
			assign l_valid = valid_vec[i-1];
			assign l_alive = alive_vec[i-1];
			assign l_gt    = gt_vec[i-1];
		end

		if (i == MAX_DETECTIONS - 1) begin : g_last
			assign r_det   = '0;
			assign r_valid = 1'b0;
			assign r_alive = 1'b0;
		end else begin : g_inner
			assign r_det   = det_a[i+1];
			assign r_valid = valid_vec[i+1];
			assign r_alive = alive_vec[i+1];
		end

		dps_cell #(
			.COORD_BITS(COORD_BITS),
			.DET_W     (DET_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_det     (new_det),
			.anchor_x    (anchor_x),
			.anchor_y    (anchor_y),
			.near_dist_sq(near_dist_sq),
			.far_dist_sq (far_dist_sq),
			.left_det    (l_det),
			.left_valid  (l_valid),
			.left_alive  (l_alive),
			.left_gt     (l_gt),
			.right_det   (r_det),
			.right_valid (r_valid),
			.right_alive (r_alive),
			.det         (det_a[i]),
			.valid       (valid_vec[i]),
			.alive       (alive_vec[i]),
			.gt          (gt_vec[i])
		);
	end

	assign head_det   = det_a[0];
	assign head_valid = valid_vec[0];
	assign head_alive = alive_vec[0];
	assign any_alive  = |alive_vec;

	for (genvar k = 1; k < MAX_DETECTIONS; k++) begin : g_chk
		`DPS_ASSERT(a_packed_row, !valid_vec[k] || valid_vec[k-1], "gap in occupied cells")
	end
	`DPS_ASSERT(a_alive_occupied, (alive_vec & ~valid_vec) == '0, "survivor in an empty cell")
	`DPS_ASSERT_NEXT(a_clear_row, ctrl.clear, valid_vec == '0, "row not empty after clear")

endmodule

[src/detection_proximity_suppression.sv]
// Top level of the distance-based suppression block: frame control, registers, output
//
// Input channel (in_valid/in_ready): command 0 adds a detection (pos_x, pos_y,
// obj_class, score) to the frame; command 1 ends the frame. A detection is taken
// and placed in y order by the row of cells. Past MAX_DETECTIONS items further
// detections are dropped and the frame is marked overflowed. After an end of
// frame the block walks the sorted row from the head: a suppressed entry is
// popped; a kept one is popped, every cell compares against it for suppression,
// and it is loaded into the output register; a final step clears the frame. No
// item is taken during the walk. Output channel (out_valid/out_ready): one item
// per kept detection in y order, out_last on the final one, overflowed on all
// items of an overflowed frame. An output register decouples the channels; when
// the receiver stalls, the walk holds until the register is free, and loading
// of a new frame may start while the final item of the last one still waits.
// Reset empties the frame, drops any pending result and loads near 50, far 20000
// and keep 3. APB registers: 0x0 near_dist_sq, 0x4 far_dist_sq, 0x8 keep_count.
module detection_proximity_suppression import dps_pkg::*; #(
	parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
	parameter int COORD_BITS     = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [CLASS_BITS-1:0] obj_class,
	input  logic [SCORE_BITS-1:0] score,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [CLASS_BITS-1:0] out_class,
	output logic [SCORE_BITS-1:0] out_score,
	output logic                  out_last,
	output logic                  overflowed
);
	`include "detection_proximity_suppression_assert.svh"

	localparam int DET_W = 2 * COORD_BITS + CLASS_BITS + SCORE_BITS;
	localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_KILL = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic                  ovf_q;
	logic [KEEP_BITS-1:0]  kept_q;
	logic [DIST_BITS-1:0]  near_q;
	logic [DIST_BITS-1:0]  far_q;
	logic [KEEP_BITS-1:0]  keep_q;
	logic [DET_W-1:0]      anchor_q;
	logic                  out_valid_q;
	logic [DET_W-1:0]      out_det_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	cell_ctrl_t            ctrl;
	logic [DET_W-1:0]      new_det;
	logic [DET_W-1:0]      head_det;
	logic                  head_valid;
	logic                  head_alive;
	logic                  any_alive;
	logic                  in_acc;
	logic                  cfg_wr;
	logic [REG_IDX_BITS-1:0] cfg_idx;
	logic                  full;
	logic [KEEP_BITS-1:0]  limit;
	logic                  stop;
	logic                  out_free;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign full     = (count_q == CNT_W'(MAX_DETECTIONS));
	assign limit    = (keep_q > KEEP_BITS'(RESULT_LIMIT)) ? KEEP_BITS'(RESULT_LIMIT) : keep_q;
	assign stop     = (kept_q == limit) || !head_valid;
	assign out_free = !out_valid_q || out_ready;
	assign new_det  = {score, obj_class, pos_y, pos_x};

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_BITS-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_NEAR: prdata = 32'(near_q);
			REG_FAR:  prdata = 32'(far_q);
			REG_KEEP: prdata = 32'(keep_q);
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
			far_q  <= FAR_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NEAR: near_q <= pwdata[DIST_BITS-1:0];
				REG_FAR:  far_q  <= pwdata[DIST_BITS-1:0];
				REG_KEEP: keep_q <= pwdata[KEEP_BITS-1:0];
				default:  ;
			endcase
		end
	end

	// one row operation per cycle, chosen by the frame state
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.load  = in_acc && (command == CMD_ADD) && !full;
			ST_SCAN: ctrl.shift = !stop;
			ST_KILL: ctrl.kill  = 1'b1;
			ST_DONE: ctrl.clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			kept_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command == CMD_END) begin
							kept_q  <= '0;
							state_q <= ST_SCAN;
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (stop) begin
						state_q <= ST_DONE;
					end else if (head_alive) begin
						kept_q  <= kept_q + KEEP_BITS'(1);
						state_q <= ST_KILL;
					end
				end
				ST_KILL: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the output register from the walk, drop the item once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && !stop && head_alive) begin
			anchor_q <= head_det;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_det_q  <= anchor_q;
			// final when the quota is met or nothing survived the sweep
			out_last_q <= (kept_q == limit) || !any_alive;
			out_ovf_q  <= ovf_q;
		end
	end

	dps_chain #(
		.MAX_DETECTIONS(MAX_DETECTIONS),
		.COORD_BITS    (COORD_BITS),
		.DET_W         (DET_W)
	) u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.new_det     (new_det),
		.anchor_x    (anchor_q[COORD_BITS-1:0]),
		.anchor_y    (anchor_q[2*COORD_BITS-1:COORD_BITS]),
		.near_dist_sq(near_q),
		.far_dist_sq (far_q),
		.head_det    (head_det),
		.head_valid  (head_valid),
		.head_alive  (head_alive),
		.any_alive   (any_alive)
	);

	assign out_valid  = out_valid_q;
	assign out_x      = out_det_q[COORD_BITS-1:0];
	assign out_y      = out_det_q[2*COORD_BITS-1:COORD_BITS];
	assign out_class  = out_det_q[2*COORD_BITS+CLASS_BITS-1:2*COORD_BITS];
	assign out_score  = out_det_q[DET_W-1:2*COORD_BITS+CLASS_BITS];
	assign out_last   = out_last_q;
	assign overflowed = out_ovf_q;

	`DPS_ASSERT(a_kept_bound, kept_q <= KEEP_BITS'(RESULT_LIMIT), "kept count past limit")
	`DPS_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_DETECTIONS), "buffer count past depth")
	`DPS_ASSERT_NEXT(a_frame_cleared, state_q == ST_DONE,
		(count_q == '0) && !ovf_q, "frame not cleared")
	`DPS_ASSERT_NEXT(a_emit_holds, (state_q == ST_EMIT) && out_valid_q && !out_ready,
		(state_q == ST_EMIT) && out_valid_q, "pending item overrun")

endmodule

[tb/tb_detection_proximity_suppression.sv]
// Testbench for the distance-based detection suppression block
`timescale 1ns / 1ps

module tb_detection_proximity_suppression;
	import dps_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 150;
	localparam int LONG_HOLD      = 400;

	typedef struct packed {
		logic [COORD_BITS_DEF-1:0] x;
		logic [COORD_BITS_DEF-1:0] y;
		logic [CLASS_BITS-1:0]     cls;
		logic [SCORE_BITS-1:0]     score;
	} detection_t;

	typedef struct packed {
		logic [COORD_BITS_DEF-1:0] x;
		logic [COORD_BITS_DEF-1:0] y;
		logic [CLASS_BITS-1:0]     cls;
		logic [SCORE_BITS-1:0]     score;
		logic                      last;
		logic                      ovf;
	} kept_t;

	class frame_scoreboard;
		detection_t            frame[$];
		logic                  overflow;
		logic [DIST_BITS-1:0]  near_sq;
		logic [DIST_BITS-1:0]  far_sq;
		logic [KEEP_BITS-1:0]  keep;
		kept_t                 pending_kept[$];
		int unsigned           mismatches;

		function new();
			overflow = 1'b0;
			near_sq = NEAR_RESET;
			far_sq = FAR_RESET;
			keep = KEEP_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
			case (idx)
				REG_NEAR: near_sq = value[DIST_BITS-1:0];
				REG_FAR:  far_sq = value[DIST_BITS-1:0];
				REG_KEEP: keep = value[KEEP_BITS-1:0];
				default: ;
			endcase
		endfunction

		// sort by y (stable), then take anchors greedily and drop near or far neighbors
		function void close_frame();
			detection_t      order[$];
			bit              dropped[MAX_DETECTIONS_DEF];
			kept_t           res[$];
			kept_t           one;
			int unsigned     i, j, limit;
			longint unsigned dx, dy, dsq;
			for (i = 0; i < frame.size(); i++) begin
				j = order.size();
				while (j > 0 && order[j-1].y > frame[i].y)
					j--;
				order.insert(j, frame[i]);
				dropped[i] = 1'b0;
			end
			limit = (keep < RESULT_LIMIT) ? keep : RESULT_LIMIT;
			for (i = 0; i < order.size() && res.size() < limit; i++) begin
				if (!dropped[i]) begin
					one.x = order[i].x;
					one.y = order[i].y;
					one.cls = order[i].cls;
					one.score = order[i].score;
					one.last = 1'b0;
					one.ovf = overflow;
					res = {res, one};
					for (j = i + 1; j < order.size(); j++) begin
						if (!dropped[j]) begin
							dx = (order[i].x > order[j].x) ? order[i].x - order[j].x
								: order[j].x - order[i].x;
							dy = (order[i].y > order[j].y) ? order[i].y - order[j].y
								: order[j].y - order[i].y;
							dsq = dx * dx + dy * dy;
							if (dsq < near_sq || dsq > far_sq)
								dropped[j] = 1'b1;
						end
					end
				end
			end
			if (res.size() != 0)
				res[res.size()-1].last = 1'b1;
			pending_kept = {pending_kept, res};
			frame = {};
			overflow = 1'b0;
		endfunction

		function void take_item(logic cmd, detection_t det);
			if (cmd == CMD_ADD) begin
				if (frame.size() < MAX_DETECTIONS_DEF)
					frame = {frame, det};
				else
					overflow = 1'b1;
			end else begin
				close_frame();
			end
		endfunction

		function void report_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_kept(kept_t got);
			kept_t want;
			if (pending_kept.size() == 0) begin
				$display("%0t: unexpected item: expected none, actual x=%0d y=%0d last=%0d",
					$time, got.x, got.y, got.last);
				mismatches++;
				return;
			end
			want = pending_kept.pop_front();
			report_field("out_x", want.x, got.x);
			report_field("out_y", want.y, got.y);
			report_field("out_class", want.cls, got.cls);
			report_field("out_score", want.score, got.score);
			report_field("out_last", want.last, got.last);
			report_field("overflowed", want.ovf, got.ovf);
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_BITS-1:0]      paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic                      command;
	logic [COORD_BITS_DEF-1:0] pos_x;
	logic [COORD_BITS_DEF-1:0] pos_y;
	logic [CLASS_BITS-1:0]     obj_class;
	logic [SCORE_BITS-1:0]     score;
	logic                      out_valid;
	logic                      out_ready;
	logic [COORD_BITS_DEF-1:0] out_x;
	logic [COORD_BITS_DEF-1:0] out_y;
	logic [CLASS_BITS-1:0]     out_class;
	logic [SCORE_BITS-1:0]     out_score;
	logic                      out_last;
	logic                      overflowed;

	frame_scoreboard sb = new();
	int unsigned     send_idle_pct;
	int unsigned     stall_pct;
	int unsigned     items_sent;
	int unsigned     quiet_cycles;
	int unsigned     hold_left;
	logic            hold_go;
	logic            hold_seen;

	detection_proximity_suppression u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.obj_class  (obj_class),
		.score      (score),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_class  (out_class),
		.out_score  (out_score),
		.out_last   (out_last),
		.overflowed (overflowed)
	);

	always #10 clk = ~clk;

	// receiver: random stalls, plus a long hold-off whenever hold_go toggles
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// monitor: feed the predictor, check results, watch for a hang
	always @(posedge clk) begin
		detection_t det;
		kept_t      seen;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				det.x = pos_x;
				det.y = pos_y;
				det.cls = obj_class;
				det.score = score;
				sb.take_item(command, det);
			end
			if (out_valid && out_ready) begin
				seen.x = out_x;
				seen.y = out_y;
				seen.cls = out_class;
				seen.score = out_score;
				seen.last = out_last;
				seen.ovf = overflowed;
				sb.check_kept(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input logic cmd, input logic [COORD_BITS_DEF-1:0] x, y,
		input logic [CLASS_BITS-1:0] cls, input logic [SCORE_BITS-1:0] sc);
		if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pos_x <= x;
		pos_y <= y;
		obj_class <= cls;
		score <= sc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_end();
		send_item(CMD_END, COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom),
			CLASS_BITS'($urandom), SCORE_BITS'($urandom));
	endtask

	// a cluster around a random point, some detections scattered anywhere
	task automatic send_frame(input int unsigned n_det, input int unsigned spread);
		logic [COORD_BITS_DEF-1:0] bx, by;
		int unsigned               i;
		bx = COORD_BITS_DEF'($urandom);
		by = COORD_BITS_DEF'($urandom);
		for (i = 0; i < n_det; i++) begin
			if ($urandom_range(4, 0) == 0)
				send_item(CMD_ADD, COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom),
					CLASS_BITS'($urandom), SCORE_BITS'($urandom));
			else
				send_item(CMD_ADD,
					COORD_BITS_DEF'(bx + $urandom_range(2 * spread, 0) - spread),
					COORD_BITS_DEF'(by + $urandom_range(2 * spread, 0) - spread),
					CLASS_BITS'($urandom), SCORE_BITS'($urandom));
		end
		send_end();
	endtask

	task automatic random_frames(input int unsigned n_items);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(7, 0) == 0)
				send_end();
			else
				send_frame($urandom_range(8, 1), $urandom_range(80, 4));
		end
	endtask

	// drop valid, wait for every expected item, then let the walk finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_kept.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic set_regs(input logic [31:0] near_v, far_v, keep_v);
		write_reg(REG_NEAR, near_v);
		write_reg(REG_FAR, far_v);
		write_reg(REG_KEEP, keep_v);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_ADD;
		pos_x = '0;
		pos_y = '0;
		obj_class = '0;
		score = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_go = 1'b0;
		hold_seen = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: duplicate drop, tie in y kept in arrival order
		send_item(CMD_ADD, 100, 200, 1, 100);
		send_item(CMD_ADD, 103, 204, 2, 200);
		send_item(CMD_ADD, 90, 150, 3, 300);
		send_item(CMD_ADD, 130, 200, 4, 400);
		send_end();
		// field extremes; the far corner is edge interference
		send_item(CMD_ADD, 0, 0, 0, 0);
		send_item(CMD_ADD, 4095, 4095, 15, 65535);
		send_end();
		// empty frame
		send_end();
		wait_idle();

		// keep zero: frame is cleared with no output
		write_reg(REG_KEEP, 0);
		send_item(CMD_ADD, 10, 20, 5, 7);
		send_item(CMD_ADD, 30, 40, 6, 8);
		send_end();
		wait_idle();

		// near at max: only the first anchor survives
		set_regs(32'h3FF_FFFF, 32'h3FF_FFFF, 63);
		send_item(CMD_ADD, 500, 900, 1, 11);
		send_item(CMD_ADD, 4000, 10, 2, 22);
		send_item(CMD_ADD, 500, 900, 3, 33);
		send_item(CMD_ADD, 0, 4095, 4, 44);
		send_end();
		wait_idle();

		// near zero, far at max: identical points all kept
		set_regs(0, 32'h3FF_FFFF, 63);
		repeat (5) send_item(CMD_ADD, 2048, 1024, CLASS_BITS'($urandom), SCORE_BITS'($urandom));
		send_end();
		wait_idle();

		// no idling
		set_regs($urandom_range(2000, 0), $urandom_range(200000, 1000), $urandom_range(32, 1));
		random_frames(15);
		wait_idle();

		send_idle_pct = 45;
		set_regs($urandom_range(400, 0), $urandom_range(20000, 2000), $urandom_range(8, 1));
		random_frames(15);
		wait_idle();

		// keep above the limit saturates; an overflowing frame
		send_idle_pct = 0;
		stall_pct = 45;
		set_regs(0, 32'h3FF_FFFF, 63);
		send_frame(36, 40);
		random_frames(15);
		wait_idle();

		send_idle_pct = 22;
		stall_pct = 22;
		set_regs($urandom_range(1000, 0), $urandom_range(100000, 500), 32);
		random_frames(15);
		wait_idle();

		// hold the receiver off while frames keep coming
		send_idle_pct = 0;
		stall_pct = 0;
		set_regs(100, 32'h3FF_FFFF, 32);
		hold_go <= ~hold_go;
		send_frame(34, 60);
		random_frames(15);
		wait_idle();

		if (sb.mismatches == 0 && sb.pending_kept.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
